// ===== hdl/sbcd_pkg.sv =====
package sbcd_pkg;

  localparam int unsigned LATENCY = 7;

  localparam logic [2:0] ADDR_BASE_YEAR = 3'd0;
  localparam logic [6:0] BASE_YEAR_RESET = 7'd70;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [8:0] DAYS_YEAR = 9'd365;
  localparam logic [10:0] DAYS_CYCLE = 11'd1461;

  localparam logic [25:0] RECIP_DAY = 26'd50903317;
  localparam logic [17:0] RECIP_HOUR = 18'd149131;
  localparam logic [16:0] RECIP_CYCLE = 17'd91868;
  localparam logic [12:0] RECIP_MIN = 13'd4370;

  typedef enum logic {
    CMD_TO_BCD = 1'b0,
    CMD_TO_SECONDS = 1'b1
  } cmd_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0: d = 9'd0;
      4'd1: d = 9'd31;
      4'd2: d = 9'd59;
      4'd3: d = 9'd90;
      4'd4: d = 9'd120;
      4'd5: d = 9'd151;
      4'd6: d = 9'd181;
      4'd7: d = 9'd212;
      4'd8: d = 9'd243;
      4'd9: d = 9'd273;
      4'd10: d = 9'd304;
      4'd11: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [10:0] cycle_offset(input logic [1:0] r);
    logic [10:0] o;
    case (r)
      2'd0: o = 11'd0;
      2'd1: o = 11'd366;
      2'd2: o = 11'd731;
      default: o = 11'd1096;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0] tens;
    logic [6:0] ones;
    p = v * 8'd205;
    tens = p[14:11];
    ones = v - 7'(tens * 4'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

endpackage

// ===== hdl/sbcd_split.sv =====
module sbcd_split
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] seconds_in,
  input  logic [6:0]  base_year,
  output logic [6:0]  bcd_second,
  output logic [6:0]  bcd_minute,
  output logic [5:0]  bcd_hour,
  output logic [5:0]  bcd_date,
  output logic [4:0]  bcd_month,
  output logic [7:0]  bcd_year,
  output logic        year_over
);

  logic [31:0] s1, s2;
  logic [50:0] p1;
  logic [6:0]  y01, y02, yb3, yb4, yb5;
  logic [15:0] day2;
  logic [16:0] hms3, hms4, dd3, dd4;
  logic [34:0] ph4;
  logic [33:0] pc4;
  logic [4:0]  hr5, hr6;
  logic [11:0] r5, r6;
  logic [5:0]  q5;
  logic [10:0] rem5;
  logic [24:0] pm6;
  logic [8:0]  doy6, y6;
  logic        leap6;

  logic [1:0]  c5;
  logic [10:0] cum5;
  logic [5:0]  mn7;
  logic [11:0] sc7;
  logic [3:0]  m7;
  logic [8:0]  mcum7, date7, ymod7;

  always_comb begin
    if (rem5 >= 11'd1096) begin
      c5 = 2'd3;
    end else if (rem5 >= 11'd731) begin
      c5 = 2'd2;
    end else if (rem5 >= 11'd366) begin
      c5 = 2'd1;
    end else begin
      c5 = 2'd0;
    end
    cum5 = cycle_offset(c5);
  end

  always_comb begin
    mn7 = pm6[23:18];
    sc7 = r6 - 12'(mn7 * SECS_PER_MIN);
    m7 = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy6 >= days_before(4'(i)) + 9'((leap6 && i >= 2) ? 1 : 0)) begin
        m7 = 4'(i);
      end
    end
    mcum7 = days_before(m7) + 9'((leap6 && m7 >= 4'd2) ? 1 : 0);
    date7 = doy6 - mcum7 + 9'd1;
    if (y6 >= 9'd200) begin
      ymod7 = y6 - 9'd200;
    end else if (y6 >= 9'd100) begin
      ymod7 = y6 - 9'd100;
    end else begin
      ymod7 = y6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= seconds_in;
      p1 <= seconds_in[31:7] * RECIP_DAY;
      y01 <= base_year;

      s2 <= s1;
      day2 <= p1[50:35];
      y02 <= y01;

      hms3 <= 17'(s2 - 32'(day2 * SECS_PER_DAY));
      dd3 <= 17'(day2) + 17'(cycle_offset(y02[1:0]));
      yb3 <= {y02[6:2], 2'b00};

      hms4 <= hms3;
      dd4 <= dd3;
      yb4 <= yb3;
      ph4 <= hms3 * RECIP_HOUR;
      pc4 <= dd3 * RECIP_CYCLE;

      hr5 <= ph4[33:29];
      r5 <= 12'(hms4 - 17'(ph4[33:29] * SECS_PER_HOUR));
      q5 <= pc4[32:27];
      rem5 <= 11'(dd4 - 17'(pc4[32:27] * DAYS_CYCLE));
      yb5 <= yb4;

      hr6 <= hr5;
      r6 <= r5;
      pm6 <= r5 * RECIP_MIN;
      doy6 <= 9'(rem5 - cum5);
      leap6 <= (c5 == 2'd0);
      y6 <= 9'(yb5) + 9'({q5, 2'b00}) + 9'(c5);

      bcd_second <= 7'(to_bcd(sc7[6:0]));
      bcd_minute <= 7'(to_bcd(7'(mn7)));
      bcd_hour <= 6'(to_bcd(7'(hr6)));
      bcd_date <= 6'(to_bcd(date7[6:0]));
      bcd_month <= 5'(to_bcd(7'(m7) + 7'd1));
      bcd_year <= to_bcd(ymod7[6:0]);
      year_over <= (y6 > 9'd99);
    end
  end

endmodule

// ===== hdl/sbcd_join.sv =====
module sbcd_join
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  bcd_second_in,
  input  logic [7:0]  bcd_minute_in,
  input  logic [7:0]  bcd_hour_in,
  input  logic [7:0]  bcd_date_in,
  input  logic [7:0]  bcd_month_in,
  input  logic [7:0]  bcd_year_in,
  input  logic [6:0]  base_year,
  output logic [31:0] seconds,
  output logic        flag
);

  localparam int unsigned TAIL = LATENCY - 3;

  logic [7:0]  sec1, min1, hr1, mday1, mon1, yr1, sec2, min2, hr2;
  logic [6:0]  y01;
  logic [17:0] days2;
  logic        ok2, ok3, bad2, bad3;
  logic [31:0] pd3;
  logic [19:0] ph3;
  logic [13:0] pm3;
  logic [7:0]  sec3;
  logic [31:0] tot [TAIL];
  logic        fl [TAIL];

  logic        after2;
  logic [7:0]  n2;
  logic [15:0] ydays2;
  logic [6:0]  lp2;
  logic        mon_ok1;
  logic [35:0] prod3;

  always_comb begin
    mon_ok1 = (mon1 >= 8'd1) && (mon1 <= 8'd12);
    after2 = (yr1 > 8'(y01));
    n2 = after2 ? yr1 - 8'(y01) : 8'd0;
    lp2 = after2 ? 7'(9'(yr1 + 8'd3) >> 2) - 7'(8'(y01 + 7'd3) >> 2) : 7'd0;
    ydays2 = 16'(n2 * DAYS_YEAR) + 16'(lp2);
    prod3 = $signed(days2) * $signed({1'b0, SECS_PER_DAY});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec1 <= from_bcd(bcd_second_in);
      min1 <= from_bcd(bcd_minute_in);
      hr1 <= from_bcd(bcd_hour_in);
      mday1 <= from_bcd(bcd_date_in);
      mon1 <= from_bcd(bcd_month_in);
      yr1 <= from_bcd(bcd_year_in);
      y01 <= base_year;

      days2 <= 18'(ydays2) + 18'(days_before(mon1[3:0] - 4'd1))
             + 18'((yr1[1:0] == 2'd0 && mon1 > 8'd2) ? 1 : 0) + 18'(mday1) - 18'd1;
      ok2 <= mon_ok1;
      bad2 <= (yr1 > 8'd99);
      sec2 <= sec1;
      min2 <= min1;
      hr2 <= hr1;

      pd3 <= prod3[31:0];
      ph3 <= hr2 * SECS_PER_HOUR;
      pm3 <= min2 * SECS_PER_MIN;
      sec3 <= sec2;
      ok3 <= ok2;
      bad3 <= bad2;

      tot[0] <= ok3 ? pd3 + 32'(ph3) + 32'(pm3) + 32'(sec3) : 32'd0;
      fl[0] <= !ok3 || bad3;
      for (int i = 1; i < TAIL; i++) begin
        tot[i] <= tot[i-1];
        fl[i] <= fl[i-1];
      end
    end
  end

  assign seconds = tot[TAIL-1];
  assign flag = fl[TAIL-1];

endmodule

// ===== hdl/seconds_bcd_calendar_converter.sv =====
// Converts a seconds count since the start of base_year into BCD calendar bytes (command 0),
// or BCD calendar bytes back into a seconds count modulo 2^32 (command 1). The datapath is a
// seven stage pipeline: one request is taken every cycle while the output is not stalled.
// A stalled output freezes every stage, so in_ready follows out_ready whenever a result
// is waiting. base_year sits at byte address 0 of the APB port and resets to 70.
module seconds_bcd_calendar_converter
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] seconds_in,
  input  logic [7:0]  bcd_second_in,
  input  logic [7:0]  bcd_minute_in,
  input  logic [7:0]  bcd_hour_in,
  input  logic [7:0]  bcd_date_in,
  input  logic [7:0]  bcd_month_in,
  input  logic [7:0]  bcd_year_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] seconds_out,
  output logic [6:0]  bcd_second_out,
  output logic [6:0]  bcd_minute_out,
  output logic [5:0]  bcd_hour_out,
  output logic [5:0]  bcd_date_out,
  output logic [4:0]  bcd_month_out,
  output logic [7:0]  bcd_year_out,
  output logic        out_of_range
);

  logic [6:0] base_year;
  logic [LATENCY-1:0] vld;
  cmd_t cmd_pipe [LATENCY];
  logic en;

  logic [6:0] s_sec, s_min;
  logic [5:0] s_hr, s_date;
  logic [4:0] s_mon;
  logic [7:0] s_yr;
  logic s_over, j_flag;
  logic [31:0] j_sec;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BASE_YEAR) ? {25'd0, base_year} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_BASE_YEAR) begin
      base_year <= pwdata[6:0];
    end
  end

  assign out_valid = vld[LATENCY-1];
  assign en = out_ready || !out_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_pipe[0] <= cmd_t'(command);
      for (int i = 1; i < LATENCY; i++) begin
        cmd_pipe[i] <= cmd_pipe[i-1];
      end
    end
  end

  sbcd_split u_split (
    .clk        (clk),
    .en         (en),
    .seconds_in (seconds_in),
    .base_year  (base_year),
    .bcd_second (s_sec),
    .bcd_minute (s_min),
    .bcd_hour   (s_hr),
    .bcd_date   (s_date),
    .bcd_month  (s_mon),
    .bcd_year   (s_yr),
    .year_over  (s_over)
  );

  sbcd_join u_join (
    .clk           (clk),
    .en            (en),
    .bcd_second_in (bcd_second_in),
    .bcd_minute_in (bcd_minute_in),
    .bcd_hour_in   (bcd_hour_in),
    .bcd_date_in   (bcd_date_in),
    .bcd_month_in  (bcd_month_in),
    .bcd_year_in   (bcd_year_in),
    .base_year     (base_year),
    .seconds       (j_sec),
    .flag          (j_flag)
  );

  always_comb begin
    if (cmd_pipe[LATENCY-1] == CMD_TO_SECONDS) begin
      seconds_out = j_sec;
      bcd_second_out = '0;
      bcd_minute_out = '0;
      bcd_hour_out = '0;
      bcd_date_out = '0;
      bcd_month_out = '0;
      bcd_year_out = '0;
      out_of_range = j_flag;
    end else begin
      seconds_out = '0;
      bcd_second_out = s_sec;
      bcd_minute_out = s_min;
      bcd_hour_out = s_hr;
      bcd_date_out = s_date;
      bcd_month_out = s_mon;
      bcd_year_out = s_yr;
      out_of_range = s_over;
    end
  end

endmodule

// ===== hdl/sbcd_checker.sv =====
module sbcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] bcd_second_out,
  input logic [4:0] bcd_month_out,
  input logic [31:0] seconds_out
);

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow the output side");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_modes_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && seconds_out != 32'd0 |-> bcd_month_out == 5'd0 && bcd_second_out == 7'd0)
    else $error("both result kinds present");

endmodule

bind seconds_bcd_calendar_converter sbcd_checker u_sbcd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .bcd_second_out (bcd_second_out),
  .bcd_month_out  (bcd_month_out),
  .seconds_out    (seconds_out)
);
